// ===== hw/rtl/galloping_threshold_prober_defines.svh =====
`ifndef GALLOPING_THRESHOLD_PROBER_DEFINES_SVH
`define GALLOPING_THRESHOLD_PROBER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define GTP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define GTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gtp_pkg.sv =====
`default_nettype none

package gtp_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] reason_t;

  localparam cmd_t CMD_PROBE  = 2'd0;
  localparam cmd_t CMD_CENSOR = 2'd1;
  localparam cmd_t CMD_RESET  = 2'd2;

  localparam status_t ST_CHOSEN   = 2'd0;
  localparam status_t ST_CLOSED   = 2'd1;
  localparam status_t ST_INVERTED = 2'd2;

  localparam reason_t RSN_UPPER_MINUS_ONE = 2'd0;
  localparam reason_t RSN_GEOMETRIC       = 2'd1;
  localparam reason_t RSN_MIDPOINT        = 2'd2;

  typedef struct packed {
    status_t status;
    reason_t reason;
  } res_tag_t;

  typedef struct packed {
    logic take;
    logic emit;
  } core_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gtp_if.sv =====
`default_nettype none

interface gtp_in_if #(parameter int W = 32);
  logic            valid;
  logic            ready;
  gtp_pkg::cmd_t   cmd;
  logic [W-1:0]    lower_bound;
  logic [W-1:0]    upper_bound;

  modport source(output valid, cmd, lower_bound, upper_bound, input ready);
  modport sink(input valid, cmd, lower_bound, upper_bound, output ready);
endinterface

interface gtp_out_if #(parameter int W = 32);
  logic             valid;
  logic             ready;
  logic [W-1:0]     threshold;
  gtp_pkg::status_t status;
  gtp_pkg::reason_t reason;

  modport source(output valid, threshold, status, reason, input ready);
  modport sink(input valid, threshold, status, reason, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/galloping_threshold_prober.sv =====
// Galloping threshold prober: takes one request per cycle while results are taken
// (cmd 0 probe, 1 censored note, 2 reset, 3 ignored) and returns exactly one result
// per probe, none for the other commands. A request is captured in an input
// register and is evaluated from there against the search state (galloping
// offset, bisection flag, remembered bounds); a probe waits in the input register
// until the result register has room and then loads it, so the sustained rate is
// one request per cycle as long as results are taken. Input ready follows output
// ready combinationally through the single evaluation stage. The channels' width
// parameter must equal BOUND_WIDTH.
`default_nettype none

module galloping_threshold_prober #(
  parameter int BOUND_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  gtp_in_if.sink    in_chan,
  gtp_out_if.source out_chan
);
  import gtp_pkg::*;

  logic                   in_v_r;
  cmd_t                   cmd_r;
  logic [BOUND_WIDTH-1:0] lo_r;
  logic [BOUND_WIDTH-1:0] hi_r;

  logic                   out_v_r;
  logic [BOUND_WIDTH-1:0] thr_r;
  res_tag_t               tag_r;

  logic                   res_room;
  core_ctl_t              ctl;
  logic [BOUND_WIDTH-1:0] thr_c;
  res_tag_t               tag_c;

  assign res_room      = !out_v_r || out_chan.ready;
  assign in_chan.ready = !in_v_r || ctl.take;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      cmd_r <= in_chan.cmd;
      lo_r  <= in_chan.lower_bound;
      hi_r  <= in_chan.upper_bound;
    end
  end

  gtp_step_core #(
    .W(BOUND_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_v_r),
    .cmd        (cmd_r),
    .lo         (lo_r),
    .hi         (hi_r),
    .res_room   (res_room),
    .ctl        (ctl),
    .threshold  (thr_c),
    .tag        (tag_c)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_room) begin
      out_v_r <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      thr_r <= thr_c;
      tag_r <= tag_c;
    end
  end

  assign out_chan.valid     = out_v_r;
  assign out_chan.threshold = thr_r;
  assign out_chan.status    = tag_r.status;
  assign out_chan.reason    = tag_r.reason;

endmodule

`default_nettype wire

// ===== hw/rtl/gtp_step_core.sv =====
`default_nettype none

module gtp_step_core #(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  gtp_pkg::cmd_t      cmd,
  input  logic [W-1:0]       lo,
  input  logic [W-1:0]       hi,
  input  logic               res_room,
  output gtp_pkg::core_ctl_t ctl,
  output logic [W-1:0]       threshold,
  output gtp_pkg::res_tag_t  tag
);
  import gtp_pkg::*;

  localparam logic [W:0] OFF_ONE = (W+1)'(1);

  logic         seen_r, seen_nxt;
  logic [W-1:0] klo_r, klo_nxt;
  logic [W-1:0] khi_r, khi_nxt;
  logic [W:0]   off_r, off_nxt;
  logic         bis_r, bis_nxt;

  logic         is_probe;
  logic         fresh;
  logic [W:0]   eff_off;
  logic         eff_bis;
  logic [W-1:0] span;
  logic [W-1:0] mid;
  logic         off_big;
  logic [W-1:0] cand;
  logic         cand_low;

  assign is_probe = (cmd == CMD_PROBE);
  assign fresh    = !seen_r || (lo != klo_r) || (hi != khi_r);
  assign eff_off  = fresh ? OFF_ONE : off_r;
  assign eff_bis  = fresh ? 1'b0 : bis_r;
  assign span     = hi - lo;
  assign mid      = lo + (span >> 1);
  assign off_big  = eff_off > {1'b0, hi};
  assign cand     = hi - eff_off[W-1:0];
  assign cand_low = (cand <= mid) || (cand <= lo);

  always_comb begin
    seen_nxt   = seen_r;
    klo_nxt    = klo_r;
    khi_nxt    = khi_r;
    off_nxt    = off_r;
    bis_nxt    = bis_r;
    ctl.take   = item_valid && (!is_probe || res_room);
    ctl.emit   = 1'b0;
    threshold  = '0;
    tag.status = ST_CHOSEN;
    tag.reason = RSN_UPPER_MINUS_ONE;
    if (ctl.take) begin
      case (cmd)
        CMD_CENSOR: begin
          if (!bis_r) begin
            if (off_r[W]) begin
              bis_nxt = 1'b1;
            end else begin
              off_nxt = {off_r[W-1:0], 1'b0};
            end
          end
        end
        CMD_RESET: begin
          seen_nxt = 1'b0;
          klo_nxt  = '0;
          khi_nxt  = '0;
          off_nxt  = OFF_ONE;
          bis_nxt  = 1'b0;
        end
        CMD_PROBE: begin
          ctl.emit = 1'b1;
          if (lo > hi) begin
            tag.status = ST_INVERTED;
          end else if (lo == hi) begin
            tag.status = ST_CLOSED;
          end else begin
            if (fresh) begin
              seen_nxt = 1'b1;
              klo_nxt  = lo;
              khi_nxt  = hi;
              off_nxt  = OFF_ONE;
              bis_nxt  = 1'b0;
            end
            if (eff_bis) begin
              threshold  = mid;
              tag.reason = RSN_MIDPOINT;
            end else if (off_big || cand_low) begin
              bis_nxt    = 1'b1;
              threshold  = mid;
              tag.reason = RSN_MIDPOINT;
            end else begin
              threshold  = cand;
              tag.reason = (eff_off == OFF_ONE) ? RSN_UPPER_MINUS_ONE : RSN_GEOMETRIC;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      klo_r  <= '0;
      khi_r  <= '0;
      off_r  <= OFF_ONE;
      bis_r  <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
      klo_r  <= klo_nxt;
      khi_r  <= khi_nxt;
      off_r  <= off_nxt;
      bis_r  <= bis_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gtp_checker.sv =====
`default_nettype none
`include "galloping_threshold_prober_defines.svh"

module gtp_checker #(
  parameter int W = 32
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [W-1:0]     out_threshold,
  input gtp_pkg::status_t out_status,
  input gtp_pkg::reason_t out_reason
);
  import gtp_pkg::*;

  `GTP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `GTP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_threshold) && $stable(out_status) && $stable(out_reason), "stalled result changed")
  `GTP_ASSERT_NOW(a_no_thr, out_valid && (out_status != ST_CHOSEN), (out_threshold == '0) && (out_reason == RSN_UPPER_MINUS_ONE), "threshold or reason set without a choice")
  `GTP_ASSERT_NOW(a_reset_quiet, !$past(rst_n), !out_valid, "result right after reset")

endmodule

bind galloping_threshold_prober gtp_checker #(
  .W(BOUND_WIDTH)
) u_gtp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_threshold (out_chan.threshold),
  .out_status    (out_chan.status),
  .out_reason    (out_chan.reason)
);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import gtp_pkg::*;

  localparam int BW = 32;
  localparam cmd_t CMD_UNUSED = 2'd3;

  typedef logic [BW-1:0] bound_t;

  typedef struct packed {
    bound_t  threshold;
    status_t status;
    reason_t reason;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;

  gtp_in_if  #(.W(BW)) in_chan ();
  gtp_out_if #(.W(BW)) out_chan ();

  galloping_threshold_prober #(.BOUND_WIDTH(BW)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  // search state as the block should hold it
  bit          have_bounds = 1'b0;
  bound_t      held_lower  = '0;
  bound_t      held_upper  = '0;
  logic [BW:0] gallop_step = 1;
  bit          bisecting   = 1'b0;

  verdict_t expected_verdicts[$];
  int       mismatches    = 0;
  int       requests_sent = 0;
  int       hold_left     = 0;
  bit       steady        = 1'b0;

  function automatic bit advance_search(input cmd_t c, input bound_t lo, input bound_t hi,
                                        output verdict_t v);
    bound_t mid;
    bound_t cand;
    bit     produced;
    v = '0;
    produced = 1'b0;
    case (c)
      CMD_CENSOR: begin
        if (!bisecting) begin
          if (gallop_step[BW]) bisecting = 1'b1;
          else gallop_step = gallop_step << 1;
        end
      end
      CMD_RESET: begin
        have_bounds = 1'b0;
        held_lower = '0;
        held_upper = '0;
        gallop_step = 1;
        bisecting = 1'b0;
      end
      CMD_PROBE: begin
        produced = 1'b1;
        if (lo > hi) begin
          v.status = ST_INVERTED;
        end else if (lo == hi) begin
          v.status = ST_CLOSED;
        end else begin
          if (!have_bounds || lo != held_lower || hi != held_upper) begin
            held_lower = lo;
            held_upper = hi;
            gallop_step = 1;
            bisecting = 1'b0;
            have_bounds = 1'b1;
          end
          mid = lo + ((hi - lo) >> 1);
          cand = hi - gallop_step[BW-1:0];
          v.status = ST_CHOSEN;
          if (bisecting || gallop_step > {1'b0, hi} || cand <= mid || cand <= lo) begin
            bisecting = 1'b1;
            v.threshold = mid;
            v.reason = RSN_MIDPOINT;
          end else begin
            v.threshold = cand;
            v.reason = (gallop_step == 1) ? RSN_UPPER_MINUS_ONE : RSN_GEOMETRIC;
          end
        end
      end
      default: ;
    endcase
    return produced;
  endfunction

  task automatic report_mismatch(string what, bound_t got, bound_t want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_request(cmd_t c, bound_t lo, bound_t hi);
    int       gap;
    verdict_t v;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.cmd <= c;
    in_chan.lower_bound <= lo;
    in_chan.upper_bound <= hi;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (advance_search(c, lo, hi, v)) expected_verdicts = {expected_verdicts, v};
    requests_sent++;
  endtask

  // result side: random stalls, long hold on demand, and checking
  initial begin : result_taker
    int       wait_left;
    int       w;
    verdict_t want;
    wait_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected result", out_chan.threshold, '0);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_chan.threshold !== want.threshold)
            report_mismatch("threshold", out_chan.threshold, want.threshold);
          if (out_chan.status !== want.status)
            report_mismatch("status", bound_t'(out_chan.status), bound_t'(want.status));
          if (out_chan.reason !== want.reason)
            report_mismatch("reason", bound_t'(out_chan.reason), bound_t'(want.reason));
        end
      end
      if (!rst_n) begin
        out_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (wait_left > 0) begin
        out_chan.ready <= 1'b0;
        wait_left--;
      end else if (out_chan.valid && out_chan.ready) begin
        w = steady ? 0 : $urandom_range(0, 7);
        if (w > 0) begin
          out_chan.ready <= 1'b0;
          wait_left = w - 1;
        end else begin
          out_chan.ready <= 1'b1;
        end
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  task automatic pick_interval(output bound_t lo, output bound_t hi);
    bound_t a;
    bound_t b;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 3))
      0: begin
        if (a == b) b = a ^ 1;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
      1: begin
        if (a > 32'hFFFF_FF00) a = a - 32'd256;
        lo = a;
        hi = a + bound_t'($urandom_range(1, 40));
      end
      2: begin
        lo = '0;
        hi = (b == 0) ? 32'd1 : b;
      end
      default: begin
        lo = (a == '1) ? '0 : a;
        hi = '1;
      end
    endcase
  endtask

  task automatic test_bad_intervals();
    send_request(CMD_PROBE, 32'd1, 32'd0);
    send_request(CMD_PROBE, '1, '0);
    send_request(CMD_PROBE, '0, '0);
    send_request(CMD_PROBE, '1, '1);
    send_request(CMD_PROBE, 32'd5, 32'd5);
  endtask

  task automatic test_gallop_to_bisection();
    send_request(CMD_PROBE, '0, '1);
    send_request(CMD_PROBE, '0, '1);
    send_request(CMD_PROBE, 32'd0, 32'd1000);
    repeat (3) begin
      send_request(CMD_CENSOR, '1, '1);
      send_request(CMD_PROBE, 32'd0, 32'd1000);
    end
    repeat (6) send_request(CMD_CENSOR, '0, '0);
    send_request(CMD_PROBE, 32'd0, 32'd1000);
    send_request(CMD_CENSOR, '0, '0);
    send_request(CMD_PROBE, 32'd0, 32'd1000);
  endtask

  task automatic test_offset_above_upper();
    send_request(CMD_PROBE, 32'd0, 32'd3);
    send_request(CMD_CENSOR, '0, '0);
    send_request(CMD_CENSOR, '0, '0);
    send_request(CMD_PROBE, 32'd0, 32'd3);
    send_request(CMD_PROBE, 32'd0, 32'd1);
    send_request(CMD_PROBE, 32'd0, 32'd2);
  endtask

  task automatic test_reset_and_unused();
    send_request(CMD_PROBE, 32'd10, 32'd20);
    send_request(CMD_CENSOR, 32'd10, 32'd20);
    send_request(CMD_UNUSED, 32'd10, 32'd20);
    send_request(CMD_PROBE, 32'd10, 32'd20);
    send_request(CMD_RESET, '1, '1);
    send_request(CMD_PROBE, 32'd10, 32'd20);
  endtask

  task automatic test_offset_saturation();
    send_request(CMD_PROBE, '0, '1);
    repeat (33) send_request(CMD_CENSOR, '0, '0);
    send_request(CMD_PROBE, '0, '1);
    repeat (3) send_request(CMD_CENSOR, '0, '0);
    send_request(CMD_PROBE, '0, '1);
    send_request(CMD_PROBE, 32'd1, '1);
  endtask

  task automatic test_backpressure();
    steady = 1'b1;
    hold_left = 150;
    send_request(CMD_PROBE, 32'd0, 32'd4096);
    repeat (30) begin
      send_request(CMD_CENSOR, '0, '0);
      send_request(CMD_PROBE, 32'd0, 32'd4096);
    end
    steady = 1'b0;
  endtask

  task automatic test_random_sessions();
    bound_t lo;
    bound_t hi;
    int     steps;
    int     pick;
    int     censor_pct;
    int     stop_at;
    stop_at = requests_sent + 270;
    while (requests_sent < stop_at) begin
      steady = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        pick_interval(lo, hi);
        send_request(CMD_PROBE, lo, hi);
        if (pick < 6) begin
          steps = $urandom_range(20, 40);
          censor_pct = 70;
        end else begin
          steps = $urandom_range(1, 10);
          censor_pct = 45;
        end
        repeat (steps) begin
          pick = $urandom_range(0, 99);
          if (pick < censor_pct) send_request(CMD_CENSOR, $urandom, $urandom);
          else if (pick < 90) send_request(CMD_PROBE, lo, hi);
          else if (pick < 95) send_request(CMD_UNUSED, $urandom, $urandom);
          else if (pick < 98) send_request(CMD_PROBE, $urandom, $urandom);
          else send_request(CMD_RESET, $urandom, $urandom);
        end
      end else begin
        lo = $urandom;
        hi = $urandom;
        case ($urandom_range(0, 3))
          0: send_request(cmd_t'($urandom_range(0, 3)), lo, hi);
          1: send_request(CMD_PROBE, (lo > hi) ? lo : hi, (lo > hi) ? hi : lo);
          2: send_request(CMD_PROBE, lo, lo);
          default: send_request(CMD_RESET, lo, hi);
        endcase
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.cmd <= CMD_PROBE;
    in_chan.lower_bound <= '0;
    in_chan.upper_bound <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_bad_intervals();
    test_gallop_to_bisection();
    test_offset_above_upper();
    test_reset_and_unused();
    test_offset_saturation();
    test_backpressure();
    test_random_sessions();
    in_chan.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
